// File: rtl/core/sfta_pkg.sv
// Shared types and constants for the strip/fan triangle assembler.
// No dependencies; imported by every module of the block.
package sfta_pkg;

  localparam int CMD_W      = 16;
  localparam int VTX_W      = 4 * CMD_W;
  localparam int PART_W     = 3 * CMD_W;
  localparam int COUNT_BITS = 20;
  localparam int TOTAL_W    = 20;
  localparam int CORNERS    = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_POS,
    PH_NRM,
    PH_S,
    PH_T
  } phase_t;

  typedef logic [CMD_W-1:0] word_t;
  typedef logic [VTX_W-1:0] vtx_t;

  // group of results handed from the assembler to the emitter
  typedef struct packed {
    logic [1:0]               cnt;
    logic                     mesh_end;
    logic [TOTAL_W-1:0]       total;
    logic [CORNERS-1:0][VTX_W-1:0] vtx;
  } batch_t;

endpackage

// File: rtl/core/strip_fan_triangle_assembler_core.sv
// Strip/fan triangle assembler: turns a mesh command stream into triangle corner words.
// Path: input word register, then the sfta_emit result register once load_ok allows.
// Throughput: one input word per cycle unless stalled; a completed triangle's three
// corners leave the single result register while the next vertex's 4 words come in.
// A zero header after a triangle's t word stalls input until its last corner is taken.
// Reset (rst_n low, synchronous): expects a run header, corner count cleared, no results.
module strip_fan_triangle_assembler_core
  import sfta_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_cmd_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_position_index,
  output logic signed [15:0] out_normal_index,
  output logic signed [15:0] out_tex_s,
  output logic signed [15:0] out_tex_t,
  output logic [1:0]         out_corner,
  output logic               out_mesh_end,
  output logic [19:0]        out_vertex_total,
  output logic               out_last_of_run
);

  batch_t batch;
  logic   batch_load;
  logic   load_ok;
  word_t  pos_w, nrm_w, s_w, t_w;

  sfta_asm u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd_word (word_t'(in_cmd_word)),
    .load_ok     (load_ok),
    .batch_load  (batch_load),
    .batch       (batch)
  );

  sfta_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .batch_load         (batch_load),
    .batch              (batch),
    .load_ok            (load_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_position_index (pos_w),
    .out_normal_index   (nrm_w),
    .out_tex_s          (s_w),
    .out_tex_t          (t_w),
    .out_corner         (out_corner),
    .out_mesh_end       (out_mesh_end),
    .out_vertex_total   (out_vertex_total),
    .out_last_of_run    (out_last_of_run)
  );

  assign out_position_index = signed'(pos_w);
  assign out_normal_index   = signed'(nrm_w);
  assign out_tex_s          = signed'(s_w);
  assign out_tex_t          = signed'(t_w);

endmodule

// File: rtl/core/sfta_asm.sv
// Input word register, run/vertex state and triangle formation.
// Depends on sfta_pkg; feeds result groups to sfta_emit.
module sfta_asm
  import sfta_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  word_t  in_cmd_word,
  input  logic   load_ok,
  output logic   batch_load,
  output batch_t batch
);

  logic                  in_vld_r, in_vld_nxt;
  word_t                 in_word_r;
  phase_t                phase_r, phase_nxt;
  logic [CMD_W-1:0]      left_r, left_nxt;
  logic                  fan_r, fan_nxt;
  logic [CMD_W-1:0]      ord_r, ord_nxt;
  logic [PART_W-1:0]     part_r, part_nxt;
  vtx_t                  anchor_r, anchor_nxt;
  vtx_t                  prev_r, prev_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic             wzero, ord_ge2, needs_out, go, accept;
  logic [CMD_W-1:0] left_dec;
  vtx_t             cur_v;

  assign wzero     = (in_word_r == '0);
  assign ord_ge2   = |ord_r[CMD_W-1:1];
  assign needs_out = ((phase_r == PH_HDR) && wzero) || ((phase_r == PH_T) && ord_ge2);
  assign go        = in_vld_r && (!needs_out || load_ok);
  assign in_stall  = in_vld_r && !go;
  assign accept    = in_valid && !in_stall;
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : '0;
  assign cur_v     = {in_word_r, part_r};
  assign batch_load = go && needs_out;

  assign in_vld_nxt = accept ? 1'b1 : (go ? 1'b0 : in_vld_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      unique case (phase_r)
        PH_HDR:  phase_nxt = wzero ? PH_HDR : PH_POS;
        PH_POS:  phase_nxt = PH_NRM;
        PH_NRM:  phase_nxt = PH_S;
        PH_S:    phase_nxt = PH_T;
        PH_T:    phase_nxt = (left_dec == '0) ? PH_HDR : PH_POS;
        default: phase_nxt = PH_HDR;
      endcase
    end
  end

  // datapath and result group
  always_comb begin
    left_nxt   = left_r;
    fan_nxt    = fan_r;
    ord_nxt    = ord_r;
    part_nxt   = part_r;
    anchor_nxt = anchor_r;
    prev_nxt   = prev_r;
    count_nxt  = count_r;
    batch      = '0;
    if (go) begin
      unique case (phase_r)
        PH_HDR: begin
          if (wzero) begin
            batch.cnt      = 2'd1;
            batch.mesh_end = 1'b1;
            batch.total    = TOTAL_W'(count_r);
            count_nxt      = '0;
          end else begin
            fan_nxt  = in_word_r[CMD_W-1];
            left_nxt = in_word_r[CMD_W-1] ? CMD_W'(-in_word_r) : in_word_r;
            ord_nxt  = '0;
            part_nxt = '0;
          end
        end
        PH_POS: part_nxt[CMD_W-1:0]         = in_word_r;
        PH_NRM: part_nxt[2*CMD_W-1:CMD_W]   = in_word_r;
        PH_S:   part_nxt[3*CMD_W-1:2*CMD_W] = in_word_r;
        PH_T: begin
          if (ord_r == '0) begin
            anchor_nxt = cur_v;
          end else if (!ord_ge2) begin
            prev_nxt = cur_v;
          end else begin
            batch.cnt    = 2'd3;
            batch.vtx[0] = anchor_r;
            if (fan_r || !ord_r[0]) begin
              batch.vtx[1] = prev_r;
              batch.vtx[2] = cur_v;
            end else begin
              batch.vtx[1] = cur_v;
              batch.vtx[2] = prev_r;
            end
            if (!fan_r) anchor_nxt = prev_r;
            prev_nxt = cur_v;
            if (count_r >= COUNT_MAX - COUNT_BITS'(CORNERS)) count_nxt = COUNT_MAX;
            else count_nxt = count_r + COUNT_BITS'(CORNERS);
          end
          ord_nxt  = ord_r + 1'b1;
          part_nxt = '0;
          left_nxt = left_dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_HDR;
      left_r   <= '0;
      fan_r    <= 1'b0;
      ord_r    <= '0;
      count_r  <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      fan_r    <= fan_nxt;
      ord_r    <= ord_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_word_r <= in_cmd_word;
    part_r   <= part_nxt;
    anchor_r <= anchor_nxt;
    prev_r   <= prev_nxt;
  end

  a_left_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HDR) |-> (left_r != '0))
    else $error("vertex phase with no vertices left");

  a_tri_on_t: assert property (@(posedge clk) disable iff (!rst_n)
    (batch_load && !batch.mesh_end) |-> (phase_r == PH_T && ord_ge2 && batch.cnt == 2'd3))
    else $error("triangle group formed outside t word");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(count_r) == COUNT_MAX && $past(phase_r) != PH_HDR) |-> (count_r == COUNT_MAX))
    else $error("saturated count moved");

endmodule

// File: rtl/core/sfta_emit.sv
// Result register: holds one group of up to three results and hands them out in order.
// Depends on sfta_pkg; loaded by sfta_asm.
module sfta_emit
  import sfta_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               batch_load,
  input  batch_t             batch,
  output logic               load_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output word_t              out_position_index,
  output word_t              out_normal_index,
  output word_t              out_tex_s,
  output word_t              out_tex_t,
  output logic [1:0]         out_corner,
  output logic               out_mesh_end,
  output logic [TOTAL_W-1:0] out_vertex_total,
  output logic               out_last_of_run
);

  logic [1:0]                    cnt_r, cnt_nxt;
  logic [1:0]                    idx_r, idx_nxt;
  logic [CORNERS-1:0][VTX_W-1:0] vtx_r;
  logic                          end_r;
  logic [TOTAL_W-1:0]            total_r;
  logic                          take;
  vtx_t                          sel_v;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (batch_load) begin
      cnt_nxt = batch.cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      cnt_nxt = cnt_r - 1'b1;
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_v = vtx_r[0];
      2'd1:    sel_v = vtx_r[1];
      2'd2:    sel_v = vtx_r[2];
      default: sel_v = '0;
    endcase
  end

  assign out_position_index = sel_v[CMD_W-1:0];
  assign out_normal_index   = sel_v[2*CMD_W-1:CMD_W];
  assign out_tex_s          = sel_v[3*CMD_W-1:2*CMD_W];
  assign out_tex_t          = sel_v[4*CMD_W-1:3*CMD_W];
  assign out_corner         = idx_r;
  assign out_mesh_end       = end_r;
  assign out_vertex_total   = total_r;
  assign out_last_of_run    = (cnt_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      vtx_r   <= batch.vtx;
      end_r   <= batch.mesh_end;
      total_r <= batch.total;
    end
  end

  a_tri_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !end_r) |-> ((idx_r + cnt_r) == 2'd3))
    else $error("corner index out of step with remaining count");

  a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && end_r) |-> (cnt_r == 2'd1 && idx_r == 2'd0))
    else $error("end-of-mesh group longer than one word");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cnt_r == 2'd1 && !batch_load) |=> (cnt_r == 2'd0))
    else $error("emitter did not drain after last word");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (batch_load && cnt_r != 2'd0) |-> (cnt_r == 2'd1 && take))
    else $error("group loaded over pending results");

endmodule

// File: tb/sv/tb_strip_fan_triangle_assembler_core.sv
// Self-checking testbench for strip_fan_triangle_assembler_core: queued command words,
// bursty driver, stalling receiver, in-line triangle assembly model. Needs sfta_pkg and
// the core RTL only.
`timescale 1ns / 1ps

module tb_strip_fan_triangle_assembler_core;
  import sfta_pkg::*;

  localparam int     LIMIT_CYCLES  = 100_000;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     DRAIN_CYCLES  = 20;
  localparam int     RANDOM_WORDS  = 130;
  localparam int     QUEUE_HIGH    = 2048;
  localparam word_t  MESH_END_WORD = '0;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_QUARTER,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    logic signed [15:0] pos;
    logic signed [15:0] nrm;
    logic signed [15:0] s;
    logic signed [15:0] t;
    logic [1:0]         corner;
    logic               mesh_end;
    logic [19:0]        total;
    logic               last;
  } corner_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_cmd_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_position_index;
  logic signed [15:0] out_normal_index;
  logic signed [15:0] out_tex_s;
  logic signed [15:0] out_tex_t;
  logic [1:0]         out_corner;
  logic               out_mesh_end;
  logic [19:0]        out_vertex_total;
  logic               out_last_of_run;

  word_t          cmd_queue[$];
  corner_result_t pending_corners[$];
  int             words_pushed = 0;
  int             words_accepted = 0;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             hold_left = 0;
  logic           hold_request = 1'b0;
  logic           hold_done = 1'b0;
  logic [31:0]    stall_cycle = '0;
  stall_mode_t    stall_mode = STALL_NONE;

  // assembler model state
  phase_t       asm_phase = PH_HDR;
  logic [15:0]  asm_left = '0;
  logic         asm_fan = 1'b0;
  logic [15:0]  asm_ordinal = '0;
  vtx_t         asm_partial = '0;
  vtx_t         asm_anchor = '0;
  vtx_t         asm_prev = '0;
  logic [19:0]  asm_emitted = '0;

  strip_fan_triangle_assembler_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd_word        (in_cmd_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_position_index (out_position_index),
    .out_normal_index   (out_normal_index),
    .out_tex_s          (out_tex_s),
    .out_tex_t          (out_tex_t),
    .out_corner         (out_corner),
    .out_mesh_end       (out_mesh_end),
    .out_vertex_total   (out_vertex_total),
    .out_last_of_run    (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_corner(input vtx_t v, input logic [1:0] c);
    corner_result_t r;
    r.pos      = v[15:0];
    r.nrm      = v[31:16];
    r.s        = v[47:32];
    r.t        = v[63:48];
    r.corner   = c;
    r.mesh_end = 1'b0;
    r.total    = '0;
    r.last     = (c == 2'd2);
    pending_corners.insert(pending_corners.size(), r);
  endtask

  task automatic assemble_word(input word_t w);
    corner_result_t r;
    vtx_t           v;
    case (asm_phase)
      PH_HDR: begin
        if (w == MESH_END_WORD) begin
          r.pos      = '0;
          r.nrm      = '0;
          r.s        = '0;
          r.t        = '0;
          r.corner   = '0;
          r.mesh_end = 1'b1;
          r.total    = asm_emitted;
          r.last     = 1'b1;
          pending_corners.insert(pending_corners.size(), r);
          asm_emitted = '0;
        end else begin
          asm_fan     = w[15];
          asm_left    = w[15] ? 16'(-w) : w;
          asm_ordinal = '0;
          asm_partial = '0;
          asm_phase   = PH_POS;
        end
      end
      PH_POS: begin
        asm_partial[15:0] = w;
        asm_phase = PH_NRM;
      end
      PH_NRM: begin
        asm_partial[31:16] = w;
        asm_phase = PH_S;
      end
      PH_S: begin
        asm_partial[47:32] = w;
        asm_phase = PH_T;
      end
      default: begin
        v = {w, asm_partial[47:0]};
        if (asm_ordinal == 16'd0) begin
          asm_anchor = v;
        end else if (asm_ordinal == 16'd1) begin
          asm_prev = v;
        end else begin
          push_corner(asm_anchor, 2'd0);
          if (asm_fan || !asm_ordinal[0]) begin
            push_corner(asm_prev, 2'd1);
            push_corner(v, 2'd2);
          end else begin
            push_corner(v, 2'd1);
            push_corner(asm_prev, 2'd2);
          end
          if (!asm_fan) asm_anchor = asm_prev;
          asm_prev = v;
          if (asm_emitted >= COUNT_MAX - 20'd3) asm_emitted = COUNT_MAX;
          else asm_emitted = asm_emitted + 20'd3;
        end
        asm_ordinal = asm_ordinal + 16'd1;
        asm_partial = '0;
        if (asm_left != 16'd0) asm_left = asm_left - 16'd1;
        asm_phase = (asm_left == 16'd0) ? PH_HDR : PH_POS;
      end
    endcase
  endtask

  // driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_cmd_word <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        assemble_word(in_cmd_word);
        words_accepted <= words_accepted + 1;
      end
      if (in_valid && in_stall) begin
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        in_valid    <= 1'b1;
        in_cmd_word <= cmd_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) gap_left <= 0;
          else gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_HALF:     out_stall <= 1'($urandom_range(0, 1));
          STALL_QUARTER:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: out_stall <= ((stall_cycle % 5) < 2);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [19:0] expv,
                             input logic [19:0] actv);
    if (expv !== actv) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, expv, actv);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    corner_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_corners.size() == 0) begin
        $display("%0t ns: unexpected word, expected none actual pos %0d mesh_end %0b",
                 $time, out_position_index, out_mesh_end);
        mismatch_count++;
      end else begin
        e = pending_corners.pop_front();
        check_field("position_index", e.pos, out_position_index);
        check_field("normal_index", e.nrm, out_normal_index);
        check_field("tex_s", e.s, out_tex_s);
        check_field("tex_t", e.t, out_tex_t);
        check_field("corner", e.corner, out_corner);
        check_field("mesh_end", e.mesh_end, out_mesh_end);
        check_field("vertex_total", e.total, out_vertex_total);
        check_field("last_of_run", e.last, out_last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("strip_fan_triangle_assembler_core: mismatch");
      $finish;
    end
  end

  task automatic push_word(input word_t w);
    while (cmd_queue.size() > QUEUE_HIGH) @(posedge clk);
    cmd_queue.insert(cmd_queue.size(), w);
    words_pushed++;
  endtask

  function automatic word_t vertex_field();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic push_run(input int n, input logic fan, input logic wild);
    word_t hdr;
    hdr = 16'(n);
    if (fan) hdr = -hdr;
    push_word(hdr);
    for (int i = 0; i < 4 * n; i++) push_word(wild ? word_t'($urandom) : vertex_field());
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty mesh, strip with extreme fields, end, fans and a short strip, end
    push_word(MESH_END_WORD);
    push_word(16'd4);
    push_word(16'h7fff); push_word(16'h8000); push_word(16'h0000); push_word(16'hffff);
    push_word(16'h8000); push_word(16'h7fff); push_word(16'hffff); push_word(16'h0000);
    push_word(16'h5555); push_word(16'haaaa); push_word(16'h0001); push_word(16'hfffe);
    push_word(16'haaaa); push_word(16'h5555); push_word(16'hfffe); push_word(16'h0001);
    push_word(MESH_END_WORD);
    push_run(3, 1'b1, 1'b0);
    push_run(1, 1'b0, 1'b0);
    push_run(2, 1'b1, 1'b0);
    push_word(MESH_END_WORD);

    // random meshes; long receiver hold-off while the sender keeps offering
    hold_request <= 1'b1;
    target = words_pushed + RANDOM_WORDS;
    while (words_pushed < target) begin
      case ($urandom_range(0, 9))
        0:       push_word(MESH_END_WORD);
        1:       push_run($urandom_range(8, 12), 1'($urandom_range(0, 1)), 1'b1);
        2:       push_run($urandom_range(1, 2), 1'($urandom_range(0, 1)), 1'b0);
        default: push_run($urandom_range(3, 7), 1'($urandom_range(0, 1)), 1'b0);
      endcase
    end
    push_word(MESH_END_WORD);

    while (words_accepted != words_pushed) @(posedge clk);
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("strip_fan_triangle_assembler_core: match");
    else $display("strip_fan_triangle_assembler_core: mismatch");
    $finish;
  end

endmodule
